// ===== rtl/pstd_pkg.sv =====
// Shared constants, types and arithmetic helpers of the peer score table.
package pstd_pkg;

    // Table geometry and field widths
    localparam int CAPACITY    = 64;
    localparam int SCORE_WIDTH = 32;
    localparam int KEY_W       = 64;
    localparam int DELTA_W     = 32;
    localparam int FIELD_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int SUM_W       = ((SCORE_WIDTH > DELTA_W) ? SCORE_WIDTH : DELTA_W) + 1;
    localparam int PROD_W      = 2 * SCORE_WIDTH;

    // Decay subtracts the magnitude divided by DECAY_DIV, found with a reciprocal multiply
    localparam int DECAY_DIV   = 50;
    localparam int RECIP_SH    = SCORE_WIDTH + 5;
    localparam logic [SCORE_WIDTH-1:0] DECAY_RECIP =
        SCORE_WIDTH'((128'd1 << RECIP_SH) / DECAY_DIV);

    // Saturation limits at the widened sum width
    localparam logic signed [SUM_W-1:0] SCORE_MAX =
        {{(SUM_W-SCORE_WIDTH+1){1'b0}}, {(SCORE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SCORE_MIN =
        {{(SUM_W-SCORE_WIDTH+1){1'b1}}, {(SCORE_WIDTH-1){1'b0}}};

    // Command codes
    localparam logic CMD_ADJUST = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_TICK = 2'd2
    } t_status;

    typedef logic        [IDX_W-1:0]       t_idx;
    typedef logic        [CNT_W-1:0]       t_cnt;
    typedef logic        [KEY_W-1:0]       t_key;
    typedef logic signed [DELTA_W-1:0]     t_delta;
    typedef logic signed [SCORE_WIDTH-1:0] t_score;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [FIELD_W-1:0]     t_field;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic upd;
        logic tick_rd;
        logic tick_mul;
        logic tick_wb;
        logic load_out;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_end;
        logic tick_vld;
        logic tick_last;
        logic out_free;
    } t_dp_sts;

    // Saturating add of a delta to a score
    function automatic t_score sat_add(input t_score old, input t_delta d);
        t_sum sum;
        sum = t_sum'(old) + t_sum'(d);
        if (sum > SCORE_MAX) begin
            sum = SCORE_MAX;
        end else if (sum < SCORE_MIN) begin
            sum = SCORE_MIN;
        end
        return sum[SCORE_WIDTH-1:0];
    endfunction

    // Score to output field: low bits, sign extended when narrower
    function automatic t_field to_field(input t_score s);
        t_sum w;
        w = t_sum'(s);
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/pstd_in_if.sv =====
// Input channel: command word with peer tag and delta.
interface pstd_in_if import pstd_pkg::*;;
    logic   valid;
    logic   ready;
    logic   cmd;
    t_key   peer_key;
    t_delta delta;

    modport source (output valid, output cmd, output peer_key, output delta, input ready);
    modport sink   (input valid, input cmd, input peer_key, input delta, output ready);
endinterface

// ===== rtl/pstd_out_if.sv =====
// Output channel: result word with score and status.
interface pstd_out_if import pstd_pkg::*;;
    logic                valid;
    logic                ready;
    t_field              score;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output score, output status, input ready);
    modport sink   (input valid, input score, input status, output ready);
endinterface

// ===== rtl/pstd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pstd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pstd_datapath.sv =====
// Datapath: tag and score memories, valid bits, scan, decay arithmetic, result register.
module pstd_datapath import pstd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ctl_cmd i_cmd,
    output t_dp_sts  o_sts,
    input  logic     i_in_cmd,
    input  t_key     i_in_key,
    input  t_delta   i_in_delta,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_field   o_out_score,
    output t_status  o_out_status
);
    // Captured word
    logic    r_cmd;
    t_key    r_key;
    t_delta  r_delta;

    // Entry valid bits
    logic [CAPACITY-1:0] r_valid;

    // Scan pipeline
    t_cnt    r_iss_cnt;
    t_idx    r_rd_idx;
    logic    r_rd_vld;
    logic    r_free_fnd;
    t_idx    r_free_idx;
    logic    r_hit;
    logic    r_free_ok;
    t_idx    r_idx;
    t_score  r_old;

    // Decay walk
    t_idx                    r_tk_idx;
    logic                    r_tk_neg;
    logic                    r_tk_zero;
    logic [SCORE_WIDTH-1:0]  r_tk_mag;
    logic [PROD_W-1:0]       r_tk_prod;

    // Result and output register
    t_field  r_res_score;
    t_status r_res_status;
    logic    r_out_vld;
    t_field  r_out_score;
    t_status r_out_status;

    // Memory ports
    t_key    w_tag_q;
    t_score  w_score_q;
    logic    w_rd_en;
    t_idx    w_raddr;
    logic    w_tag_we;
    logic    w_score_we;
    t_idx    w_score_waddr;
    t_score  w_score_wdata;

    // Scan evaluation
    logic    w_cur_valid;
    logic    w_hit;
    logic    w_cur_free;
    logic    w_last;
    logic    w_issue;

    // Update
    t_score  w_new;
    logic    w_dnz;
    logic    w_alloc;
    logic    w_upd_wr;

    // Decay arithmetic
    logic [SCORE_WIDTH-1:0] w_mag;
    logic [SCORE_WIDTH-1:0] w_q0;
    logic [SCORE_WIDTH-1:0] w_rem;
    logic [SCORE_WIDTH-1:0] w_q;
    logic [SCORE_WIDTH-1:0] w_step;
    logic [SCORE_WIDTH-1:0] w_mag_n;
    t_score                 w_s_n;
    logic                   w_free_now;

    // Memories
    pstd_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_tag_q)
    );

    pstd_ram #(.WIDTH(SCORE_WIDTH), .DEPTH(CAPACITY)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (w_score_we),
        .i_waddr (w_score_waddr),
        .i_wdata (w_score_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_score_q)
    );

    assign w_rd_en = i_cmd.scan_step | i_cmd.tick_rd;
    assign w_raddr = (r_cmd == CMD_TICK) ? r_tk_idx : r_iss_cnt[IDX_W-1:0];

    // Scan: compare the entry read last cycle, issue the next read
    assign w_issue     = r_iss_cnt < CNT_W'(CAPACITY);
    assign w_cur_valid = r_valid[r_rd_idx];
    assign w_hit       = r_rd_vld && w_cur_valid && (w_tag_q == r_key);
    assign w_cur_free  = r_rd_vld && !w_cur_valid;
    assign w_last      = r_rd_vld && (r_rd_idx == IDX_W'(CAPACITY - 1));

    // Adjust: saturating add on matched score, or on zero for a new entry
    assign w_new    = sat_add(r_old, r_delta);
    assign w_dnz    = r_delta != '0;
    assign w_alloc  = i_cmd.upd && !r_hit && w_dnz && r_free_ok;
    assign w_upd_wr = i_cmd.upd && w_dnz && (r_hit || r_free_ok);
    assign w_tag_we = w_alloc;

    // Decay: magnitude times reciprocal, then one correction step
    assign w_mag   = w_score_q[SCORE_WIDTH-1] ? (~w_score_q + 1'b1) : w_score_q;
    assign w_q0    = SCORE_WIDTH'(r_tk_prod[PROD_W-1:RECIP_SH]);
    assign w_rem   = r_tk_mag - (w_q0 * SCORE_WIDTH'(DECAY_DIV));
    assign w_q     = w_q0 + SCORE_WIDTH'(w_rem >= SCORE_WIDTH'(DECAY_DIV));
    assign w_step  = (w_q == '0) ? SCORE_WIDTH'(1) : w_q;
    assign w_mag_n = r_tk_mag - w_step;
    assign w_s_n   = r_tk_neg ? (~w_mag_n + 1'b1) : w_mag_n;
    assign w_free_now = r_tk_zero || (w_mag_n == '0);

    // Score write port is shared by adjust and decay
    assign w_score_we    = w_upd_wr || (i_cmd.tick_wb && !r_tk_zero);
    assign w_score_waddr = i_cmd.tick_wb ? r_tk_idx : r_idx;
    assign w_score_wdata = i_cmd.tick_wb ? w_s_n : w_new;

    // Status to controller
    assign o_sts.scan_end  = w_hit || w_last;
    assign o_sts.tick_vld  = r_valid[r_tk_idx];
    assign o_sts.tick_last = r_tk_idx == IDX_W'(CAPACITY - 1);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= w_issue;
            end
            if (w_alloc) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.tick_wb && w_free_now) begin
                r_valid[r_tk_idx] <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd        <= i_in_cmd;
            r_key        <= i_in_key;
            r_delta      <= i_in_delta;
            r_iss_cnt    <= '0;
            r_free_fnd   <= 1'b0;
            r_tk_idx     <= '0;
            r_res_score  <= '0;
            r_res_status <= (i_in_cmd == CMD_TICK) ? ST_TICK : ST_OK;
        end

        if (i_cmd.scan_step) begin
            if (w_issue) begin
                r_iss_cnt <= r_iss_cnt + 1'b1;
                r_rd_idx  <= r_iss_cnt[IDX_W-1:0];
            end
            if (w_cur_free && !r_free_fnd) begin
                r_free_fnd <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (w_hit || w_last) begin
                r_hit     <= w_hit;
                r_idx     <= (w_hit || !r_free_fnd) ? r_rd_idx : r_free_idx;
                r_free_ok <= r_free_fnd || w_cur_free;
                r_old     <= w_hit ? w_score_q : '0;
            end
        end

        // Adjust result
        if (i_cmd.upd) begin
            if (r_hit) begin
                r_res_score  <= to_field(w_dnz ? w_new : r_old);
                r_res_status <= ST_OK;
            end else if (w_dnz && r_free_ok) begin
                r_res_score  <= to_field(w_new);
                r_res_status <= ST_OK;
            end else if (w_dnz) begin
                r_res_score  <= '0;
                r_res_status <= ST_FULL;
            end else begin
                r_res_score  <= '0;
                r_res_status <= ST_OK;
            end
        end

        // Decay walk
        if (i_cmd.tick_rd && !r_valid[r_tk_idx]) begin
            r_tk_idx <= r_tk_idx + 1'b1;
        end
        if (i_cmd.tick_mul) begin
            r_tk_neg  <= w_score_q[SCORE_WIDTH-1];
            r_tk_zero <= w_score_q == '0;
            r_tk_mag  <= w_mag;
            r_tk_prod <= PROD_W'(w_mag) * PROD_W'(DECAY_RECIP);
        end
        if (i_cmd.tick_wb) begin
            r_tk_idx <= r_tk_idx + 1'b1;
        end

        if (i_cmd.load_out) begin
            r_out_score  <= r_res_score;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_score  = r_out_score;
    assign o_out_status = r_out_status;
endmodule

// ===== rtl/pstd_ctrl.sv =====
// Controller: sequences the scan, update, decay walk and result hand-off.
module pstd_ctrl import pstd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_cmd,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_UPD    = 7'b0000100,
        S_TK_RD  = 7'b0001000,
        S_TK_MUL = 7'b0010000,
        S_TK_WB  = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = r_state == S_IDLE;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_in_cmd == CMD_TICK) ? S_TK_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_RESP;
            end
            S_TK_RD: begin
                o_cmd.tick_rd = 1'b1;
                if (i_sts.tick_vld) begin
                    n_state = S_TK_MUL;
                end else if (i_sts.tick_last) begin
                    n_state = S_RESP;
                end
            end
            S_TK_MUL: begin
                o_cmd.tick_mul = 1'b1;
                n_state = S_TK_WB;
            end
            S_TK_WB: begin
                o_cmd.tick_wb = 1'b1;
                n_state = i_sts.tick_last ? S_RESP : S_TK_RD;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/peer_score_table_with_decay_core.sv =====
// Top level of the peer score table with decay.
// Keeps up to CAPACITY signed scores keyed by a 64-bit peer tag in two RAMs
// (tag and score) plus one valid flip-flop per entry. One word is worked on
// at a time; the next word is taken while the previous result waits in the
// output register. An adjust or read walks the tag RAM one entry per cycle
// through its single read port until it finds a match or reaches the last
// entry. A decay tick walks every entry: a valid entry is read, its
// magnitude is multiplied by the reciprocal, then corrected and written
// back; a free entry is only read and skipped. No clearing pass is needed
// after reset.
module peer_score_table_with_decay_core import pstd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pstd_in_if.sink   i_in,
    pstd_out_if.source o_out
);
    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;
    t_status  w_out_status;

    pstd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pstd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_cmd     (i_in.cmd),
        .i_in_key     (i_in.peer_key),
        .i_in_delta   (i_in.delta),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_score  (o_out.score),
        .o_out_status (w_out_status)
    );

    assign o_out.status = w_out_status;

    // Block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while a word is in progress");

    // A loaded result shows on the output next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_out.valid)
        else $error("loaded result not presented");

    // Tick and table-full results carry a zero score
    a_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_TICK) |-> o_out.score == '0)
        else $error("tick result with nonzero score");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_FULL) |-> o_out.score == '0)
        else $error("table-full result with nonzero score");
endmodule
